>>> rtl/core/tpom_pkg.sv
// Package for the true-peak oversampling meter.
// Holds the transaction structs, fixed-point widths and the interpolation
// coefficient table; no dependencies.
package tpom_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int MAG_W     = 25;
  localparam int COEF_W    = 16;
  localparam int TAPS      = 12;
  // The last tap carries a zero weight in every phase, so only 11 are live.
  localparam int LIVE_TAPS = TAPS - 1;
  // History row kept per channel: the samples feeding taps 1 to 10.
  localparam int ROW_TAPS  = LIVE_TAPS - 1;
  localparam int ROW_W     = ROW_TAPS * SAMPLE_W;
  localparam int INTERP    = 3;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int ACC_W     = 42;
  localparam int RND_SHIFT = 15;
  localparam int RES_W     = ACC_W - RND_SHIFT;
  localparam int GROUP_N   = 4;
  localparam int GROUPS    = (LIVE_TAPS + GROUP_N - 1) / GROUP_N;

  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (RND_SHIFT - 1);

  // Interpolating phases at 0.25, 0.5 and 0.75, Q1.15, taps newest first.
  localparam logic signed [COEF_W-1:0] COEF [INTERP][LIVE_TAPS] = '{
    '{16'sd29144, 16'sd6541, -16'sd4499, 16'sd2861, -16'sd1714, 16'sd957,
      -16'sd492, 16'sd223, -16'sd85, 16'sd26, -16'sd7},
    '{16'sd20591, 16'sd16384, -16'sd6953, 16'sd4171, -16'sd2431, 16'sd1334,
      -16'sd678, 16'sd305, -16'sd115, 16'sd36, -16'sd7},
    '{16'sd6541, 16'sd29144, -16'sd4499, 16'sd2861, -16'sd1714, 16'sd957,
      -16'sd492, 16'sd223, -16'sd85, 16'sd26, -16'sd7}
  };

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       channel;
    logic                       clear_peak;
  } item_t;

  typedef struct packed {
    logic [MAG_W-1:0] true_peak;
    logic [MAG_W-1:0] position_peak;
  } result_t;

endpackage

>>> rtl/core/tpom_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds while rd_en is low; no package dependency.
module tpom_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/true_peak_oversampling_meter_top.sv
// True-peak meter, 4x polyphase oversampling, top level.
// Depends on tpom_pkg and tpom_ram (per-channel history rows).
//
//   port group   | dir | payload  | transfer when
//   item_*       | in  | item_t   | item_valid && !item_stall
//   result_*     | out | result_t | result_valid && !result_stall
//
// One transaction per cycle sustained while result_stall stays low; a result
// passes history read, multiply, partial sums, round and max in that order.
// The history RAM read-modify-write spans the read and the stage 1 write;
// back-to-back samples of one channel are served by forwarding the row just written.
// Reset clears the peak, pipeline valids and per-row valid bits; no sweep.
// result_stall backs up the pipeline stage by stage; item_stall rises only
// once every stage is full.
module true_peak_oversampling_meter_top import tpom_pkg::*; #(
  parameter int CHANNELS = 2
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int AW = $clog2(CHANNELS > 1 ? CHANNELS : 2);

  // ---------------- handshake chain ----------------
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4, rdy_out;
  logic accept;

  assign rdy_out    = !result_valid || !result_stall;
  assign rdy4       = !v4 || rdy_out;
  assign rdy3       = !v3 || rdy4;
  assign rdy2       = !v2 || rdy3;
  assign rdy1       = !v1 || rdy2;
  assign item_stall = !rdy1;
  assign accept     = item_valid && rdy1;

  // ---------------- history read ----------------
  logic          in_present;
  logic [AW-1:0] in_addr;
  logic [CHANNELS-1:0] row_valid;

  assign in_present = int'(item.channel) < CHANNELS;
  assign in_addr    = in_present ? AW'(item.channel) : '0;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [ROW_W-1:0] wr_row;
  logic [ROW_W-1:0] ram_q;

  tpom_ram #(
    .WIDTH (ROW_W),
    .DEPTH (CHANNELS)
  ) u_hist (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_row),
    .rd_en   (accept),
    .rd_addr (in_addr),
    .rd_data (ram_q)
  );

  // ---------------- stage 1: row select, new row, multiply ----------------
  logic signed [SAMPLE_W-1:0] s1_sample;
  logic [AW-1:0]              s1_addr;
  logic                       s1_present, s1_clear, s1_fwd, s1_rvalid;
  logic [ROW_W-1:0]           fwd_row;
  logic [ROW_W-1:0]           s1_row;
  logic signed [SAMPLE_W-1:0] s1_taps [LIVE_TAPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample  <= item.sample;
      s1_addr    <= in_addr;
      s1_present <= in_present;
      s1_clear   <= item.clear_peak;
      s1_rvalid  <= row_valid[in_addr];
      // the RAM returns the old row when the previous transaction writes it now
      s1_fwd     <= wr_en && in_present && (wr_addr == in_addr);
    end
  end

  assign s1_row = s1_fwd ? fwd_row : (s1_rvalid ? ram_q : '0);

  always_comb begin
    s1_taps[0] = s1_sample;
    for (int t = 1; t < LIVE_TAPS; t++) begin
      s1_taps[t] = s1_row[(t-1)*SAMPLE_W +: SAMPLE_W];
    end
  end

  // shift newest first: drop the oldest entry
  assign wr_row  = {s1_row[(ROW_TAPS-1)*SAMPLE_W-1:0], s1_sample};
  assign wr_en   = v1 && rdy2 && s1_present;
  assign wr_addr = s1_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_row <= wr_row;
    end
  end

  // ---------------- stage 2: products ----------------
  logic signed [PROD_W-1:0]   s2_prod [INTERP][LIVE_TAPS];
  logic signed [SAMPLE_W-1:0] s2_sample;
  logic                       s2_present, s2_clear;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      for (int p = 0; p < INTERP; p++) begin
        for (int t = 0; t < LIVE_TAPS; t++) begin
          s2_prod[p][t] <= PROD_W'(s1_taps[t]) * PROD_W'(COEF[p][t]);
        end
      end
      s2_sample  <= s1_sample;
      s2_present <= s1_present;
      s2_clear   <= s1_clear;
    end
  end

  // ---------------- stage 3: partial sums ----------------
  logic signed [ACC_W-1:0]    part_next [INTERP][GROUPS];
  logic signed [ACC_W-1:0]    s3_part   [INTERP][GROUPS];
  logic signed [SAMPLE_W-1:0] s3_sample;
  logic                       s3_present, s3_clear;

  always_comb begin
    for (int p = 0; p < INTERP; p++) begin
      for (int g = 0; g < GROUPS; g++) begin
        part_next[p][g] = '0;
      end
      for (int t = 0; t < LIVE_TAPS; t++) begin
        part_next[p][t / GROUP_N] = part_next[p][t / GROUP_N] + ACC_W'(s2_prod[p][t]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_part    <= part_next;
      s3_sample  <= s2_sample;
      s3_present <= s2_present;
      s3_clear   <= s2_clear;
    end
  end

  // ---------------- stage 4: round, magnitude, saturate ----------------
  logic signed [ACC_W-1:0] sum     [INTERP];
  logic signed [ACC_W-1:0] rnd     [INTERP];
  logic signed [RES_W-1:0] res     [INTERP];
  logic        [RES_W-1:0] res_abs [INTERP];
  logic        [MAG_W-1:0] mag_next [INTERP+1];
  logic signed [MAG_W-1:0] sample_ext;
  logic        [MAG_W-1:0] s4_mag  [INTERP+1];
  logic                    s4_present, s4_clear;

  assign sample_ext = MAG_W'(s3_sample);

  always_comb begin
    // phase 0 passes the sample through
    mag_next[0] = sample_ext[MAG_W-1] ? MAG_W'(-sample_ext) : MAG_W'(sample_ext);
    for (int p = 0; p < INTERP; p++) begin
      sum[p] = s3_part[p][0];
      for (int g = 1; g < GROUPS; g++) begin
        sum[p] = sum[p] + s3_part[p][g];
      end
      // floor((acc + half) / 2^15)
      rnd[p]     = (sum[p] + RND_HALF) >>> RND_SHIFT;
      res[p]     = rnd[p][RES_W-1:0];
      res_abs[p] = res[p][RES_W-1] ? RES_W'(-res[p]) : RES_W'(res[p]);
      mag_next[p+1] = (|res_abs[p][RES_W-1:MAG_W]) ? MAG_MAX : res_abs[p][MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_mag     <= mag_next;
      s4_present <= s3_present;
      s4_clear   <= s3_clear;
    end
  end

  // ---------------- output stage: position max, running peak ----------------
  logic [MAG_W-1:0] max01, max23, pos, peak_base, peak_next;
  logic [MAG_W-1:0] peak, position;
  logic             out_load;

  assign max01     = (s4_mag[1] > s4_mag[0]) ? s4_mag[1] : s4_mag[0];
  assign max23     = (s4_mag[3] > s4_mag[2]) ? s4_mag[3] : s4_mag[2];
  assign pos       = !s4_present ? '0 : ((max23 > max01) ? max23 : max01);
  assign peak_base = s4_clear ? '0 : peak;
  assign peak_next = (pos > peak_base) ? pos : peak_base;
  assign out_load  = v4 && rdy_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      peak         <= '0;
    end else begin
      if (rdy_out) begin
        result_valid <= v4;
      end
      if (out_load) begin
        peak <= peak_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      position <= pos;
    end
  end

  assign result.true_peak     = peak;
  assign result.position_peak = position;

  // ---------------- assertions ----------------
  a_peak_covers_position: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.true_peak >= result.position_peak))
    else $error("running peak below position peak");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (int'(wr_addr) < CHANNELS))
    else $error("history write to absent channel");

  a_fwd_present: assert property (@(posedge clk) disable iff (rst)
    (v1 && s1_fwd) |-> s1_present)
    else $error("forwarded row for absent channel");

  a_peak_monotonic: assert property (@(posedge clk) disable iff (rst)
    (out_load && !s4_clear) |=> (peak >= $past(peak)))
    else $error("running peak decreased without clear");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    (v1 && !rdy2) |-> item_stall)
    else $error("input taken while history stage is blocked");

endmodule

>>> tb/true_peak_oversampling_meter_top_tb.sv
// Testbench for true_peak_oversampling_meter_top: drives audio samples on both
// channels with random gaps and result stalls, and checks every result against
// a local 4x polyphase true-peak predictor. Depends on tpom_pkg and the RTL.
module true_peak_oversampling_meter_top_tb;
  import tpom_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_CH    = 2;
  localparam int N_TAPS  = 12;
  localparam int N_PHASE = 4;
  localparam int SETTLE  = 16;

  localparam logic signed [SAMPLE_W-1:0] FULL_POS = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] FULL_NEG = 24'sh800000;

  // Q1.15 weights per phase, newest tap first; phase 0 passes the sample through.
  localparam int PHASE_WEIGHT [N_PHASE][N_TAPS] = '{
    '{32768, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{29144, 6541, -4499, 2861, -1714, 957, -492, 223, -85, 26, -7, 0},
    '{20591, 16384, -6953, 4171, -2431, 1334, -678, 305, -115, 36, -7, 0},
    '{6541, 29144, -4499, 2861, -1714, 957, -492, 223, -85, 26, -7, 0}
  };

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall;
  result_t result;

  logic signed [SAMPLE_W-1:0] sample_rows [N_CH][N_TAPS];
  logic [MAG_W-1:0]           running_peak;
  result_t                    expected_peaks [$];
  int                         error_count;
  bit                         tx_quiet;
  bit                         rx_quiet;

  true_peak_oversampling_meter_top #(.CHANNELS(N_CH)) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Shift the sample into its channel row, then track the largest phase magnitude.
  function automatic result_t predict_peaks(item_t it);
    result_t     res;
    longint      acc;
    longint      rounded;
    longint      mag;
    logic [MAG_W-1:0] pos;
    int          ch;
    pos = '0;
    ch  = int'(it.channel);
    if (it.clear_peak) running_peak = '0;
    if (ch < N_CH) begin
      for (int t = N_TAPS - 1; t > 0; t--) sample_rows[ch][t] = sample_rows[ch][t-1];
      sample_rows[ch][0] = it.sample;
      for (int p = 0; p < N_PHASE; p++) begin
        acc = 0;
        for (int t = 0; t < N_TAPS; t++)
          acc += longint'(PHASE_WEIGHT[p][t]) * longint'(sample_rows[ch][t]);
        rounded = (acc + 64'sd16384) >>> 15;
        mag = (rounded < 0) ? -rounded : rounded;
        if (mag > longint'(MAG_MAX)) mag = longint'(MAG_MAX);
        if (MAG_W'(mag) > pos) pos = MAG_W'(mag);
      end
      if (pos > running_peak) running_peak = pos;
    end
    res.true_peak     = running_peak;
    res.position_peak = pos;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Present one transaction after a random gap and hold it until taken.
  task automatic send_sample(logic signed [SAMPLE_W-1:0] s, logic ch, logic clr);
    item_t it;
    int    gap;
    it.sample     = s;
    it.channel    = ch;
    it.clear_peak = clr;
    gap = tx_quiet ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    expected_peaks.insert(expected_peaks.size(), predict_peaks(it));
  endtask

  // Result side: stall a random number of cycles before each transaction.
  initial begin
    int wait_cycles;
    result_stall = 1'b1;
    @(negedge rst);
    forever begin
      @(negedge clk);
      wait_cycles = rx_quiet ? 0 : $urandom_range(0, 11);
      if (wait_cycles > 0) begin
        result_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_peaks.size() == 0) begin
        $display("[%0t] unexpected result: true_peak %0d position_peak %0d",
                 $time, result.true_peak, result.position_peak);
        error_count++;
      end else begin
        want = expected_peaks.pop_front();
        if (result.true_peak !== want.true_peak)
          report_mismatch("true_peak", result.true_peak, want.true_peak);
        if (result.position_peak !== want.position_peak)
          report_mismatch("position_peak", result.position_peak, want.position_peak);
      end
    end
  end

  task automatic test_extremes();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    send_sample(FULL_POS, 1'b0, 1'b0);
    send_sample(FULL_NEG, 1'b0, 1'b0);
    send_sample('0, 1'b0, 1'b0);
    send_sample(FULL_NEG, 1'b1, 1'b0);
    send_sample(FULL_POS, 1'b1, 1'b0);
    send_sample(24'sd1, 1'b0, 1'b0);
    send_sample(-24'sd1, 1'b1, 1'b0);
  endtask

  // Signs follow the half-sample phase weights, so the interpolated value
  // lands well above full scale.
  task automatic test_overshoot();
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    for (int t = 10; t >= 0; t--)
      send_sample((t < 2 || (t % 2) == 1) ? FULL_POS : FULL_NEG, 1'b1, 1'b0);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // Clear alone, and clear together with a sample that counts right away.
  task automatic test_clear_peak();
    send_sample('0, 1'b0, 1'b1);
    send_sample(24'sd1000, 1'b0, 1'b1);
    send_sample(-24'sd20, 1'b1, 1'b0);
    send_sample(FULL_NEG, 1'b0, 1'b1);
    send_sample('0, 1'b1, 1'b1);
  endtask

  task automatic test_random_stream(int count);
    int   kind;
    int   switch_odds;
    int   offset;
    logic ch;
    logic sign_flip;
    logic signed [SAMPLE_W-1:0] s;
    ch = 1'b0;
    sign_flip = 1'b0;
    switch_odds = 2;
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) begin
        tx_quiet    = ($urandom_range(0, 3) == 0);
        rx_quiet    = ($urandom_range(0, 3) == 0);
        switch_odds = $urandom_range(0, 1) ? 2 : 12;
      end
      if ($urandom_range(1, switch_odds) == 1) ch = ~ch;
      kind = $urandom_range(0, 99);
      offset = $urandom_range(0, 4095);
      if (kind < 50) begin
        s = SAMPLE_W'($urandom);
      end else if (kind < 70) begin
        s = SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
      end else if (kind < 85) begin
        s = $urandom_range(0, 1) ? FULL_POS : FULL_NEG;
      end else begin
        sign_flip = ~sign_flip;
        s = sign_flip ? SAMPLE_W'(8388607 - offset) : SAMPLE_W'(-8388608 + offset);
      end
      send_sample(s, ch, ($urandom_range(0, 19) == 0));
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    error_count  = 0;
    tx_quiet     = 1'b0;
    rx_quiet     = 1'b0;
    running_peak = '0;
    for (int c = 0; c < N_CH; c++)
      for (int t = 0; t < N_TAPS; t++) sample_rows[c][t] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_extremes();
    test_overshoot();
    test_clear_peak();
    test_random_stream(1300);

    @(negedge clk);
    item_valid <= 1'b0;
    while (expected_peaks.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (error_count == 0 && expected_peaks.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
